>>> rtl/s2x_pkg.sv
// Shared constants, types and helper functions for the Scale2x upscaler.
package s2x_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int PIXEL_BITS     = 16;
	localparam int COL_BITS       = $clog2(MAX_WIDTH);
	localparam int WCNT_BITS      = $clog2(MAX_WIDTH + 1);
	localparam int ROW_LIMIT      = 1024;
	localparam int ROW_BITS       = $clog2(ROW_LIMIT);
	localparam int HCNT_BITS      = $clog2(ROW_LIMIT + 1);
	localparam int ADDR_BITS      = 23;
	localparam int OPIX_BITS      = 16;
	localparam int OCOL_BITS      = 10;
	localparam int OROW_BITS      = 10;
	localparam int SIZE_BITS      = 11;
	localparam int PITCH_BITS     = 13;
	localparam int CFG_BITS       = 13;
	localparam int REG_IDX_BITS   = 2;
	localparam int IN_TDATA_BITS  = 16;
	localparam int FIELD_BITS     = OCOL_BITS + OROW_BITS + ADDR_BITS + 4 * OPIX_BITS;
	localparam int OUT_TDATA_BITS = ((FIELD_BITS + 7) / 8) * 8;
	localparam int PAD_BITS       = OUT_TDATA_BITS - FIELD_BITS;
	localparam int LINE_BITS      = 2 * PIXEL_BITS;
	localparam int FIFO_DEPTH     = 8;
	localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_DEST_PITCH   = 2'd2;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	typedef struct packed {
		logic first_col;
		logic last_col;
		logic first_row;
		logic last_row;
		logic interior;
	} pos_t;

	typedef struct packed {
		logic [OPIX_BITS-1:0] bottom_right;
		logic [OPIX_BITS-1:0] bottom_left;
		logic [OPIX_BITS-1:0] top_right;
		logic [OPIX_BITS-1:0] top_left;
		logic [ADDR_BITS-1:0] dest_address;
		logic [OROW_BITS-1:0] src_row;
		logic [OCOL_BITS-1:0] src_col;
		logic                 last;
	} result_t;

	function automatic logic [WCNT_BITS-1:0] clamp_width(logic [SIZE_BITS-1:0] w);
		if (w < SIZE_BITS'(2)) begin
			return WCNT_BITS'(2);
		end else if (w > SIZE_BITS'(MAX_WIDTH)) begin
			return WCNT_BITS'(MAX_WIDTH);
		end else begin
			return WCNT_BITS'(w);
		end
	endfunction

	function automatic logic [HCNT_BITS-1:0] clamp_height(logic [SIZE_BITS-1:0] h);
		if (h < SIZE_BITS'(2)) begin
			return HCNT_BITS'(2);
		end else if (h > SIZE_BITS'(ROW_LIMIT)) begin
			return HCNT_BITS'(ROW_LIMIT);
		end else begin
			return HCNT_BITS'(h);
		end
	endfunction

endpackage

>>> rtl/s2x_ram.sv
// Generic simple dual-port RAM with registered read data.
module s2x_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/s2x_core.sv
// Window registers, Scale2x rule, address math and line buffer write-back.
module s2x_core
	import s2x_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  logic [COL_BITS-1:0]   x_s1,
	input  logic [ROW_BITS-1:0]   y_s1,
	input  pix_t                  pix_s1,
	input  pos_t                  pos_s1,
	input  logic [PITCH_BITS-1:0] dest_pitch,
	input  logic [LINE_BITS-1:0]  line_rd,
	output logic                  ram_we,
	output logic [COL_BITS-1:0]   ram_waddr,
	output logic [LINE_BITS-1:0]  ram_wdata,
	output logic [1:0]            push_cnt,
	output result_t               push0,
	output result_t               push1
);

	pix_t win_q [6];
	pix_t up2, up1;
	pix_t b, e, hh, d, f;
	pix_t tl, tr, bl, br;
	logic [ADDR_BITS-1:0] prod, bdr_addr, int_addr;
	logic                 rule_on;
	logic                 emit_int, emit_bdr;
	result_t              res_int, res_bdr;

	assign up2 = line_rd[LINE_BITS-1:PIXEL_BITS];
	assign up1 = line_rd[PIXEL_BITS-1:0];

	assign b  = win_q[0];
	assign e  = win_q[1];
	assign hh = win_q[2];
	assign d  = win_q[4];
	assign f  = up1;

	assign rule_on = (b != hh) && (d != f);
	assign tl = (rule_on && (d == b))  ? d : e;
	assign tr = (rule_on && (b == f))  ? f : e;
	assign bl = (rule_on && (d == hh)) ? d : e;
	assign br = (rule_on && (hh == f)) ? f : e;

	assign prod     = ADDR_BITS'(y_s1) * ADDR_BITS'(dest_pitch);
	assign bdr_addr = {prod[ADDR_BITS-2:0], 1'b0} + ADDR_BITS'({x_s1, 1'b0});
	assign int_addr = bdr_addr - ADDR_BITS'({dest_pitch, 1'b0}) - ADDR_BITS'(2);

	assign emit_int = pos_s1.interior;
	assign emit_bdr = pos_s1.first_col | pos_s1.last_col | pos_s1.first_row | pos_s1.last_row;

	always_comb begin
		res_int.src_col      = OCOL_BITS'(x_s1 - COL_BITS'(1));
		res_int.src_row      = OROW_BITS'(y_s1 - ROW_BITS'(1));
		res_int.dest_address = int_addr;
		res_int.top_left     = OPIX_BITS'(tl);
		res_int.top_right    = OPIX_BITS'(tr);
		res_int.bottom_left  = OPIX_BITS'(bl);
		res_int.bottom_right = OPIX_BITS'(br);
		res_int.last         = ~emit_bdr;

		res_bdr.src_col      = OCOL_BITS'(x_s1);
		res_bdr.src_row      = OROW_BITS'(y_s1);
		res_bdr.dest_address = bdr_addr;
		res_bdr.top_left     = OPIX_BITS'(pix_s1);
		res_bdr.top_right    = OPIX_BITS'(pix_s1);
		res_bdr.bottom_left  = OPIX_BITS'(pix_s1);
		res_bdr.bottom_right = OPIX_BITS'(pix_s1);
		res_bdr.last         = 1'b1;

		push0    = emit_int ? res_int : res_bdr;
		push1    = res_bdr;
		push_cnt = 2'd0;
		if (valid_s1) begin
			push_cnt = 2'(emit_int) + 2'(emit_bdr);
		end
	end

	assign ram_we    = valid_s1;
	assign ram_waddr = x_s1;
	assign ram_wdata = {up1, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= up2;
			win_q[1] <= up1;
			win_q[2] <= pix_s1;
		end
	end

endmodule

>>> rtl/s2x_fifo.sv
// Result queue taking up to two items per cycle and giving one.
module s2x_fifo
	import s2x_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [1:0]               push_cnt,
	input  result_t                  push0,
	input  result_t                  push1,
	input  logic                     pop,
	output result_t                  head,
	output logic [FIFO_CNT_BITS-1:0] count
);

	result_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	assign wr_ptr_p1 = wr_ptr_q + FIFO_PTR_BITS'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push_cnt) - FIFO_CNT_BITS'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

>>> rtl/scale2x_pixel_upscaler.sv
// Top level of the Scale2x 2x pixel upscaler.
//
//  channel | signals                          | direction | item
//  --------+----------------------------------+-----------+----------------------------
//  s       | s_tvalid s_tready s_tdata        | in        | one source pixel
//  m       | m_tvalid m_tready m_tdata m_tlast| out       | one 2x2 block, tlast on last
//  cfg     | cfg_we cfg_index cfg_data        | in        | register write, no read-back
//
//  One pixel per cycle is accepted while ready; its blocks enter the result queue
//  in the cycle after (line buffer read, then window and rule) and can be taken at
//  the next edge. Pixels that cause two blocks (last column or row, from the third
//  column and row on) send each as its own output item. Input is held off while the
//  eight-entry queue, counting blocks still in the pipeline, holds more than four.
//  Reset clears counters, window and queue; line buffers need no clearing.
module scale2x_pixel_upscaler
	import s2x_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [15:0] pixel
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [9:0] src_col, [19:10] src_row, [42:20] dest_address, [58:43] top_left,
	// [74:59] top_right, [90:75] bottom_left, [106:91] bottom_right, rest zero
	output logic [OUT_TDATA_BITS-1:0] m_tdata,
	output logic                      m_tlast,
	input  logic                      cfg_we,
	input  logic [REG_IDX_BITS-1:0]   cfg_index,
	input  logic [CFG_BITS-1:0]       cfg_data
);

	logic [SIZE_BITS-1:0]     width_q, height_q;
	logic [PITCH_BITS-1:0]    pitch_q;
	logic [COL_BITS-1:0]      col_q;
	logic [ROW_BITS-1:0]      row_q;
	logic [WCNT_BITS-1:0]     wm1;
	logic [HCNT_BITS-1:0]     hm1;
	logic [WCNT_BITS-1:0]     xw;
	logic [HCNT_BITS-1:0]     yh;
	pos_t                     pos_s0;
	logic                     accept;

	logic                     valid_s1;
	logic [COL_BITS-1:0]      x_s1;
	logic [ROW_BITS-1:0]      y_s1;
	pix_t                     pix_s1;
	pos_t                     pos_s1;

	logic [LINE_BITS-1:0]     line_rd;
	logic                     ram_we;
	logic [COL_BITS-1:0]      ram_waddr;
	logic [LINE_BITS-1:0]     ram_wdata;
	logic [1:0]               push_cnt;
	result_t                  push0, push1, head;
	logic [FIFO_CNT_BITS-1:0] fifo_cnt;
	logic [FIFO_CNT_BITS:0]   occ;
	logic                     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_BITS'(1024);
			height_q <= SIZE_BITS'(768);
			pitch_q  <= PITCH_BITS'(2048);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[SIZE_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[SIZE_BITS-1:0];
				REG_DEST_PITCH:   pitch_q  <= cfg_data[PITCH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign wm1 = clamp_width(width_q) - WCNT_BITS'(1);
	assign hm1 = clamp_height(height_q) - HCNT_BITS'(1);
	assign xw  = WCNT_BITS'(col_q);
	assign yh  = HCNT_BITS'(row_q);

	always_comb begin
		pos_s0.first_col = (col_q == '0);
		pos_s0.last_col  = (xw >= wm1);
		pos_s0.first_row = (row_q == '0);
		pos_s0.last_row  = (yh >= hm1);
		pos_s0.interior  = (col_q >= COL_BITS'(2)) && (xw <= wm1) &&
		                   (row_q >= ROW_BITS'(2)) && (yh <= hm1);
	end

	assign occ      = (FIFO_CNT_BITS+1)'(fifo_cnt) +
	                  (valid_s1 ? (FIFO_CNT_BITS+1)'(2) : '0);
	assign s_tready = (occ <= (FIFO_CNT_BITS+1)'(FIFO_DEPTH - 4));
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (pos_s0.last_col) begin
					col_q <= '0;
					row_q <= pos_s0.last_row ? '0 : row_q + ROW_BITS'(1);
				end else begin
					col_q <= col_q + COL_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= col_q;
			y_s1   <= row_q;
			pix_s1 <= s_tdata[PIXEL_BITS-1:0];
			pos_s1 <= pos_s0;
		end
	end

	s2x_ram #(
		.WIDTH (LINE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	s2x_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.x_s1       (x_s1),
		.y_s1       (y_s1),
		.pix_s1     (pix_s1),
		.pos_s1     (pos_s1),
		.dest_pitch (pitch_q),
		.line_rd    (line_rd),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.push_cnt   (push_cnt),
		.push0      (push0),
		.push1      (push1)
	);

	assign pop = m_tvalid & m_tready;

	s2x_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (push0),
		.push1    (push1),
		.pop      (pop),
		.head     (head),
		.count    (fifo_cnt)
	);

	assign m_tvalid = (fifo_cnt != '0);
	assign m_tlast  = head.last;
	assign m_tdata  = {{PAD_BITS{1'b0}}, head.bottom_right, head.bottom_left, head.top_right,
	                   head.top_left, head.dest_address, head.src_row, head.src_col};

endmodule

>>> rtl/s2x_checker.sv
// Port-level assertions for the upscaler, bound to the top level.
module s2x_checker
	import s2x_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_TDATA_BITS-1:0] m_tdata,
	input logic                      m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second block of a pixel not ready after the first");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output item without a pixel accepted two cycles earlier");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input held off with an empty output queue");

endmodule

bind scale2x_pixel_upscaler s2x_checker u_s2x_checker (.*);
